[design/batch_norm_inference_assert.svh]
// ----------------------------------------------------------------------------
// batch norm inference assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef BATCH_NORM_INFERENCE_ASSERT_SVH
`define BATCH_NORM_INFERENCE_ASSERT_SVH

// condition implies consequence in the same cycle
`define BNI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define BNI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/bni_pkg.sv]
// ----------------------------------------------------------------------------
// bni_pkg
// types, constants and codes shared by the batch norm inference block
// ----------------------------------------------------------------------------
package bni_pkg;

   localparam int CHANNELS  = 1024;
   localparam int CH_W      = $clog2(CHANNELS);
   localparam int EPS_FLOOR = 168;

   // long division unit
   localparam int DIV_N_W   = 51;
   localparam int DIV_D_W   = 42;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   // integer square root unit
   localparam int SQ_W      = 51;
   localparam int SQ_R_W    = 26;

   localparam logic [23:0] MASK24 = 24'hFFFFFF;

   typedef struct packed {
      logic              kind;
      logic [9:0]        channel_index;
      logic signed [15:0] mean_value;
      logic [15:0]       variance_value;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [23:0] normalized;
      logic              saturated;
      logic [9:0]        channel_of_sample;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_EPSILON       = 2'd0,
      CSR_SCALE         = 2'd1,
      CSR_PLANE_SIZE    = 2'd2,
      CSR_CHANNEL_COUNT = 2'd3
   } csr_idx_type;

   typedef enum logic [0:0] {
      KIND_LOAD   = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      DIV_MEAN  = 2'd0,
      DIV_VAR   = 2'd1,
      DIV_RECIP = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MDIV_GO,
      ST_MDIV_WAIT,
      ST_VDIV_GO,
      ST_VDIV_WAIT,
      ST_DSUM,
      ST_DCHK,
      ST_TDIV_GO,
      ST_TDIV_WAIT,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_WRITE,
      ST_RD,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        div_start;
      div_sel_type div_sel;
      logic        sm_take;
      logic        d_take;
      logic        dsum;
      logic        inv_zero;
      logic        sqrt_start;
      logic        inv_take;
      logic        tbl_wr;
      logic        tbl_rd;
      logic        mul;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic req_kind;
      logic scale_pos;
      logic div_done;
      logic sqrt_done;
      logic d_zero;
      logic out_free;
   } sts_type;

endpackage

[design/bni_div.sv]
// ----------------------------------------------------------------------------
// bni_div
// restoring long division, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bni_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bni_pkg::DIV_N_W-1:0]   num,
   input  logic [bni_pkg::DIV_D_W-1:0]   den,
   output logic [bni_pkg::DIV_N_W-1:0]   quo,
   output logic                          busy,
   output logic                          done
);
   import bni_pkg::*;

   logic [DIV_N_W-1:0]   acc_ff, acc_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, acc_ff[DIV_N_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = num;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[DIV_N_W-2:0], ge};
         rem_in = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign quo  = acc_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

[design/bni_sqrt.sv]
// ----------------------------------------------------------------------------
// bni_sqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module bni_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bni_pkg::SQ_W-1:0]   val,
   output logic [bni_pkg::SQ_W-1:0]   root,
   output logic                       busy,
   output logic                       done
);
   import bni_pkg::*;

   logic [SQ_W-1:0] v_ff, v_in;
   logic [SQ_W-1:0] r_ff, r_in;
   logic [SQ_W-1:0] b_ff, b_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W:0]   sum;
   logic            ge;

   always_comb begin
      sum     = {1'b0, r_ff} + {1'b0, b_ff};
      ge      = {1'b0, v_ff} >= sum;
      v_in    = v_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = val;
         r_in    = '0;
         b_in    = SQ_W'(1) << (SQ_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            v_in = v_ff - sum[SQ_W-1:0];
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff == SQ_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign root = r_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

[design/bni_dp.sv]
// ----------------------------------------------------------------------------
// bni_dp
// datapath: registers, parameter tables, load arithmetic, sample multiply
// ----------------------------------------------------------------------------
module bni_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata,
   input  bni_pkg::req_type  req_payload,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output bni_pkg::rsp_type  rsp_payload,
   input  bni_pkg::cmd_type  cmd,
   output bni_pkg::sts_type  sts
);
   import bni_pkg::*;

   // configuration
   logic [23:0]        eps_ff;
   logic signed [15:0] scale_ff;
   logic [16:0]        plane_ff;
   logic [10:0]        chcnt_ff;

   // working registers
   req_type            item_ff;
   logic [23:0]        sm_ff;
   logic [23:0]        inv_ff;
   logic [DIV_D_W-1:0] d_ff;
   logic [47:0]        rd_ff;
   logic signed [49:0] prod_ff;
   logic [15:0]        pix_ff, pix_in;
   logic [CH_W-1:0]    chn_ff, chn_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [47:0]        mem [CHANNELS];

   // division and root units
   logic [DIV_N_W-1:0] div_num, div_quo;
   logic [DIV_D_W-1:0] div_den;
   logic               div_busy, div_done;
   logic [SQ_W-1:0]    sq_root;
   logic               sq_busy, sq_done;

   logic               scale_neg, scale_zero;
   logic [16:0]        mean_abs;
   logic [23:0]        eps_eff;
   logic [SQ_R_W-1:0]  s_root, s_odd;
   logic [SQ_R_W:0]    q_half;
   logic [23:0]        inv_new;
   logic signed [24:0] diff;
   logic signed [49:0] prod_in;
   logic signed [49:0] rnd;
   logic               sat_hi, sat_lo;
   logic [16:0]        ps_eff, pix_next;
   logic [10:0]        cc_eff, chn_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff   <= 24'(EPS_FLOOR);
         scale_ff <= 16'sd256;
         plane_ff <= 17'd1;
         chcnt_ff <= 11'd1;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_EPSILON:       eps_ff   <= csr_wdata;
            CSR_SCALE:         scale_ff <= csr_wdata[15:0];
            CSR_PLANE_SIZE:    plane_ff <= csr_wdata[16:0];
            CSR_CHANNEL_COUNT: chcnt_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign scale_neg  = scale_ff[15];
   assign scale_zero = (scale_ff == 16'sd0);
   assign mean_abs   = item_ff.mean_value[15] ? 17'(-17'(item_ff.mean_value))
                                             : 17'(item_ff.mean_value);
   assign eps_eff    = (eps_ff < 24'(EPS_FLOOR)) ? 24'(EPS_FLOOR) : eps_ff;

   always_comb begin
      div_num = '0;
      div_den = DIV_D_W'({scale_ff[14:0], 1'b0});
      case (cmd.div_sel)
         DIV_MEAN: div_num = DIV_N_W'({mean_abs, 9'd0}) + DIV_N_W'(scale_ff[14:0]);
         DIV_VAR:  div_num = DIV_N_W'({item_ff.variance_value, 25'd0})
                             + DIV_N_W'(scale_ff[14:0]);
         DIV_RECIP: begin
            div_num = DIV_N_W'(1) << (DIV_N_W - 1);
            div_den = d_ff;
         end
         default: ;
      endcase
   end

   bni_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .busy  (div_busy),
      .done  (div_done)
   );

   bni_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .val   (SQ_W'(div_quo)),
      .root  (sq_root),
      .busy  (sq_busy),
      .done  (sq_done)
   );

   // round half up of 2^24 / sqrt(d) from the floor root of 2^50 / d
   assign s_root  = sq_root[SQ_R_W-1:0];
   assign s_odd   = s_root[0] ? s_root : s_root - 1'b1;
   assign q_half  = ({1'b0, s_odd} + 1'b1) >> 1;
   assign inv_new = (q_half > (SQ_R_W+1)'(MASK24)) ? MASK24 : q_half[23:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      if (cmd.sm_take) begin
         sm_ff <= item_ff.mean_value[15] ? 24'(-div_quo[23:0]) : div_quo[23:0];
      end
      if (cmd.d_take) begin
         d_ff <= div_quo[DIV_D_W-1:0];
      end else if (cmd.dsum) begin
         if (scale_zero) begin
            d_ff <= DIV_D_W'(eps_eff);
         end else if (scale_neg) begin
            d_ff <= DIV_D_W'({item_ff.variance_value, 16'd0}) + DIV_D_W'(eps_ff);
         end else begin
            d_ff <= d_ff + DIV_D_W'(eps_ff);
         end
      end
      if (cmd.dsum) begin
         if (scale_zero) begin
            sm_ff <= '0;
         end else if (scale_neg) begin
            sm_ff <= 24'(item_ff.mean_value);
         end
      end
      if (cmd.inv_zero) begin
         inv_ff <= MASK24;
      end else if (cmd.inv_take) begin
         inv_ff <= inv_new;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   // parameter table: scaled mean over inverse deviation
   always_ff @(posedge clock) begin
      if (cmd.tbl_wr && (11'(item_ff.channel_index) < 11'(CHANNELS))) begin
         mem[item_ff.channel_index[CH_W-1:0]] <= {sm_ff, inv_ff};
      end
      if (cmd.tbl_rd) begin
         rd_ff <= mem[chn_ff];
      end
   end

   assign diff    = 25'(item_ff.sample) - 25'($signed(rd_ff[47:24]));
   assign prod_in = 50'(diff) * 50'($signed({1'b0, rd_ff[23:0]}));
   assign rnd     = (prod_ff + (prod_ff[49] ? 50'sd127 : 50'sd128)) >>> 8;
   assign sat_hi  = rnd > 50'sd8388607;
   assign sat_lo  = rnd < -50'sd8388608;

   // plane and channel counters
   assign ps_eff   = (plane_ff == 17'd0) ? 17'd1
                   : ((plane_ff > 17'd65536) ? 17'd65536 : plane_ff);
   assign cc_eff   = (chcnt_ff == 11'd0) ? 11'd1
                   : ((chcnt_ff > 11'(CHANNELS)) ? 11'(CHANNELS) : chcnt_ff);
   assign pix_next = {1'b0, pix_ff} + 17'd1;
   assign chn_next = 11'(chn_ff) + 11'd1;

   always_comb begin
      pix_in = pix_ff;
      chn_in = chn_ff;
      if (cmd.out_load) begin
         if (pix_next >= ps_eff) begin
            pix_in = '0;
            chn_in = (chn_next >= cc_eff) ? '0 : chn_next[CH_W-1:0];
         end else begin
            pix_in = pix_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= '0;
         chn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_ff <= pix_in;
         chn_ff <= chn_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.out_load) begin
         rsp_ff.normalized        <= sat_hi ? 24'sh7FFFFF
                                   : (sat_lo ? 24'sh800000 : rnd[23:0]);
         rsp_ff.saturated         <= sat_hi | sat_lo;
         rsp_ff.channel_of_sample <= 10'(chn_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.req_kind  = req_payload.kind;
   assign sts.scale_pos = !scale_neg && !scale_zero;
   assign sts.div_done  = div_done;
   assign sts.sqrt_done = sq_done;
   assign sts.d_zero    = (d_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   `include "batch_norm_inference_assert.svh"

   `BNI_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid_ff || rsp_ready, "pending result overwritten")
   `BNI_ASSERT_NEXT(a_load_shows, cmd.out_load, rsp_valid_ff, "loaded result not valid")
   `BNI_ASSERT_NOW(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")
   `BNI_ASSERT_NOW(a_sqrt_idle, cmd.sqrt_start, !sq_busy && !div_busy, "root started early")

endmodule

[design/bni_ctrl.sv]
// ----------------------------------------------------------------------------
// bni_ctrl
// controller: sequences parameter loads and sample requests
// ----------------------------------------------------------------------------
module bni_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output bni_pkg::cmd_type  cmd,
   input  bni_pkg::sts_type  sts
);
   import bni_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = DIV_MEAN;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (kind_type'(sts.req_kind) == KIND_SAMPLE) begin
                  state_in = ST_RD;
               end else if (sts.scale_pos) begin
                  state_in = ST_MDIV_GO;
               end else begin
                  state_in = ST_DSUM;
               end
            end
         end
         ST_MDIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MEAN;
            state_in      = ST_MDIV_WAIT;
         end
         ST_MDIV_WAIT: begin
            if (sts.div_done) begin
               cmd.sm_take = 1'b1;
               state_in    = ST_VDIV_GO;
            end
         end
         ST_VDIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VAR;
            state_in      = ST_VDIV_WAIT;
         end
         ST_VDIV_WAIT: begin
            if (sts.div_done) begin
               cmd.d_take = 1'b1;
               state_in   = ST_DSUM;
            end
         end
         ST_DSUM: begin
            cmd.dsum = 1'b1;
            state_in = ST_DCHK;
         end
         ST_DCHK: begin
            if (sts.d_zero) begin
               cmd.inv_zero = 1'b1;
               state_in     = ST_WRITE;
            end else begin
               state_in = ST_TDIV_GO;
            end
         end
         ST_TDIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_RECIP;
            state_in      = ST_TDIV_WAIT;
         end
         ST_TDIV_WAIT: begin
            cmd.div_sel = DIV_RECIP;
            if (sts.div_done) begin
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (sts.sqrt_done) begin
               cmd.inv_take = 1'b1;
               state_in     = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.tbl_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_RD: begin
            cmd.tbl_rd = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/batch_norm_inference.sv]
// ----------------------------------------------------------------------------
// batch_norm_inference
// batch normalization for inference with per-channel parameter tables
// ----------------------------------------------------------------------------
//   channel   direction   handshake          payload
//   req       in          req_valid/ready    load or sample request
//   rsp       out         rsp_valid/ready    normalized sample
//   csr       in          csr_write          epsilon, scale, plane, channels
//
// a sample request passes the table read, multiply and round states before
// the next request is accepted; the rounded result is registered for output
// a load request for positive scale runs three 51-step divisions and a
// 26-step root in shared serial units; zero or negative scale runs only the
// reciprocal division and root, and a zero denominator skips both
// a stalled result waits in the output register; the controller holds the
// next sample at its last step until that register frees up
// synchronous reset clears control state and counters; tables are not cleared
// ----------------------------------------------------------------------------
module batch_norm_inference (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bni_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bni_pkg::rsp_type  rsp_payload,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);
   import bni_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bni_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bni_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

[tb/batch_norm_inference_tb.sv]
// ----------------------------------------------------------------------------
// batch_norm_inference_tb
// self-checking bench: parameter loads and samples go in over req, a local
// predictor keeps its own tables, counters and registers, and every response
// is checked field by field against the oldest predicted response
// ----------------------------------------------------------------------------
module batch_norm_inference_tb;
   import bni_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W = $bits(req_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   rsp_type     rsp_payload;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // predictor state
   logic [23:0]        cfg_epsilon;
   logic signed [15:0] cfg_scale;
   logic [16:0]        cfg_plane;
   logic [10:0]        cfg_chans;
   longint             mean_tbl [CHANNELS];
   longint             invdev_tbl [CHANNELS];
   bit                 loaded [CHANNELS];
   int                 pixel_ctr;
   int                 chan_ctr;

   rsp_type norm_expect_q [$];
   int      errors = 0;
   bit      calm = 1'b0;

   batch_norm_inference u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint recip_root(longint unsigned d);
      longint unsigned t;
      longint unsigned s;
      longint unsigned q;
      if (d == 0) return longint'(MASK24);
      t = (64'd1 << 50) / d;
      s = int_sqrt(t);
      if (s[0] == 1'b0) s = s - 1;
      q = (s + 1) / 2;
      return (q > MASK24) ? longint'(MASK24) : longint'(q);
   endfunction

   function automatic void predict_load(int ch, logic signed [15:0] m, logic [15:0] v);
      longint s;
      longint num;
      longint mag;
      longint sm;
      longint unsigned d;
      longint unsigned eps;
      s = cfg_scale;
      eps = cfg_epsilon;
      if (s > 0) begin
         num = longint'(m) * 256;
         mag = (num < 0) ? -num : num;
         mag = (2 * mag + s) / (2 * s);
         sm = (num < 0) ? -mag : mag;
         d = ((longint'(v) << 25) + s) / (2 * s);
      end else if (s < 0) begin
         sm = m;
         d = longint'(v) << 16;
      end else begin
         sm = 0;
         d = 0;
         if (eps < EPS_FLOOR) eps = EPS_FLOOR;
      end
      d = d + eps;
      mean_tbl[ch] = sm;
      invdev_tbl[ch] = recip_root(d);
      loaded[ch] = 1'b1;
   endfunction

   function automatic void predict_sample(logic signed [15:0] x);
      longint  prod;
      longint  mag;
      longint  r;
      int      ps;
      int      cc;
      rsp_type e;
      prod = (longint'(x) - mean_tbl[chan_ctr]) * invdev_tbl[chan_ctr];
      mag = (prod < 0) ? -prod : prod;
      mag = (mag + 128) >>> 8;
      r = (prod < 0) ? -mag : mag;
      e.saturated = 1'b0;
      if (r > 8388607) begin
         r = 8388607;
         e.saturated = 1'b1;
      end
      if (r < -8388608) begin
         r = -8388608;
         e.saturated = 1'b1;
      end
      e.normalized = r[23:0];
      e.channel_of_sample = chan_ctr[9:0];
      norm_expect_q.push_back(e);
      ps = (cfg_plane == 0) ? 1 : ((cfg_plane > 65536) ? 65536 : int'(cfg_plane));
      cc = (cfg_chans == 0) ? 1 : ((cfg_chans > CHANNELS) ? CHANNELS : int'(cfg_chans));
      pixel_ctr++;
      if (pixel_ctr >= ps) begin
         pixel_ctr = 0;
         chan_ctr++;
         if (chan_ctr >= cc) chan_ctr = 0;
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (norm_expect_q.size() == 0) begin
            $error("unexpected response %h", rsp_payload);
            errors++;
         end else begin
            e = norm_expect_q.pop_front();
            if (rsp_payload.normalized !== e.normalized) begin
               $error("normalized: expected %h actual %h", e.normalized, rsp_payload.normalized);
               errors++;
            end
            if (rsp_payload.saturated !== e.saturated) begin
               $error("saturated: expected %b actual %b", e.saturated, rsp_payload.saturated);
               errors++;
            end
            if (rsp_payload.channel_of_sample !== e.channel_of_sample) begin
               $error("channel_of_sample: expected %0d actual %0d",
                      e.channel_of_sample, rsp_payload.channel_of_sample);
               errors++;
            end
         end
      end
   end

   // response back-pressure
   initial begin
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_ready = 1'b1;
         end
         @(negedge clock);
      end
   end

   task automatic send_request(req_type r);
      @(negedge clock);
      req_valid = 1'b1;
      req_payload = r;
      do @(posedge clock); while (!req_ready);
      if (r.kind == KIND_LOAD)
         predict_load(int'(r.channel_index), r.mean_value, r.variance_value);
      else
         predict_sample(r.sample);
      if (!calm && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
   endtask

   task automatic load_channel(int ch, logic [15:0] m, logic [15:0] v);
      req_type r;
      r = req_type'(REQ_W'({$urandom, $urandom}));
      r.kind = KIND_LOAD;
      r.channel_index = 10'(ch);
      r.mean_value = m;
      r.variance_value = v;
      send_request(r);
   endtask

   task automatic send_sample(logic [15:0] x);
      req_type r;
      if (!loaded[chan_ctr]) load_channel(chan_ctr, 16'($urandom), 16'($urandom));
      r = req_type'(REQ_W'({$urandom, $urandom}));
      r.kind = KIND_SAMPLE;
      r.sample = x;
      send_request(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      wait (norm_expect_q.size() == 0);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [23:0] val);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_EPSILON:       cfg_epsilon = val;
         CSR_SCALE:         cfg_scale = val[15:0];
         CSR_PLANE_SIZE:    cfg_plane = val[16:0];
         CSR_CHANNEL_COUNT: cfg_chans = val[10:0];
      endcase
   endtask

   task automatic set_config(logic [23:0] eps, logic [15:0] sc, logic [16:0] ps,
                             logic [10:0] cc);
      drain();
      write_csr(CSR_EPSILON, eps);
      write_csr(CSR_SCALE, {8'd0, sc});
      write_csr(CSR_PLANE_SIZE, {7'd0, ps});
      write_csr(CSR_CHANNEL_COUNT, {13'd0, cc});
      loaded = '{default: 1'b0};
   endtask

   task automatic test_defaults();
      load_channel(0, 16'h8000, 16'hFFFF);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      load_channel(0, 16'h7FFF, 16'h0000);
      send_sample(16'h8000);
      send_sample(16'h0000);
   endtask

   task automatic test_scale_cases();
      // zero scale floors epsilon
      set_config(24'd0, 16'h0000, 17'd1, 11'd2);
      load_channel(0, 16'h1234, 16'h4000);
      load_channel(1, 16'h8000, 16'hFFFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      // negative scale, zero denominator
      set_config(24'd0, 16'h8000, 17'd1, 11'd1);
      load_channel(0, 16'h0100, 16'h0000);
      send_sample(16'h7FFF);
      send_sample(16'h0100);
      set_config(24'hFFFFFF, 16'h7FFF, 17'd1, 11'd1);
      load_channel(0, 16'h8000, 16'hFFFF);
      send_sample(16'h7FFF);
      set_config(24'd1, 16'h0001, 17'd1, 11'd1);
      load_channel(0, 16'h7FFF, 16'hFFFF);
      send_sample(16'h8000);
      load_channel(1023, 16'h5555, 16'hAAAA);
   endtask

   task automatic test_counter_limits();
      set_config(24'd168, 16'd256, 17'd0, 11'd0);
      send_sample(16'h0200);
      send_sample(16'hFE00);
      set_config(24'd168, 16'd256, 17'h1FFFF, 11'h7FF);
      repeat (3) send_sample(16'($urandom));
   endtask

   task automatic test_random();
      int n;
      for (int phase = 0; phase < 24; phase++) begin
         logic [15:0] sc;
         case ($urandom_range(0, 5))
            0: sc = 16'h0000;
            1: sc = 16'(-$urandom_range(1, 32768));
            2: sc = 16'($urandom_range(1, 32767));
            default: sc = 16'($urandom_range(64, 1024));
         endcase
         set_config(24'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096)),
                    sc, 17'($urandom_range(1, 6)), 11'($urandom_range(1, 8)));
         if (phase == 10) drain();
         calm = (phase >= 20) || ($urandom_range(0, 4) == 0);
         n = 0;
         while (n < 65) begin
            if ($urandom_range(0, 30) == 0)
               load_channel(int'($urandom_range(0, 1023)), 16'($urandom), 16'($urandom));
            else begin
               send_sample(16'($urandom));
               n++;
            end
         end
      end
   endtask

   initial begin
      loaded = '{default: 1'b0};
      cfg_epsilon = 24'd168;
      cfg_scale = 16'sd256;
      cfg_plane = 17'd1;
      cfg_chans = 11'd1;
      pixel_ctr = 0;
      chan_ctr = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_defaults();
      test_scale_cases();
      test_counter_limits();
      test_random();
      @(negedge clock);
      req_valid = 1'b0;
      wait (norm_expect_q.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
